// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SDFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on the same edge.
`define SDFS_ASSERT_IMP(label, pre, post, msg) \
  `SDFS_ASSERT(label, (pre) |-> (post), msg)

`endif

// ===== rtl/sdfs_pkg.sv =====
// Shared types and constants of the segment display frame sender.
`timescale 1ns / 1ps
package sdfs_pkg;

  localparam int unsigned Digits    = 4;
  localparam int unsigned SegWidth  = 7;
  localparam int unsigned TableW    = 35;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned UnitW     = 3;
  localparam int unsigned BitW      = 3;

  // Unit of the frame: 0 data-set cmd, 1 address cmd, data bytes, display cmd.
  localparam logic [UnitW-1:0] UnitDataSet = UnitW'(0);
  localparam logic [UnitW-1:0] UnitAddress = UnitW'(1);
  localparam logic [UnitW-1:0] UnitLastDat = UnitW'(1 + Digits);
  localparam logic [UnitW-1:0] UnitDisplay = UnitW'(2 + Digits);

  localparam logic [7:0] StopCodeA = 8'h40;
  localparam logic [7:0] StopCodeB = 8'h80;
  localparam logic [7:0] StopCodeC = 8'h88;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDataSet  = 3'd0,
    CfgAddress  = 3'd1,
    CfgDisplay  = 3'd2,
    CfgSegLow   = 3'd3,
    CfgSegHigh  = 3'd4
  } cfg_idx_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic             load_digits;
    logic             load_shift;
    logic [UnitW-1:0] unit_sel;
    logic             clk_set;
    logic             clk_clr;
    logic             dio_set;
    logic             dio_clr;
    logic             dio_bit;
    logic [BitW-1:0]  bit_sel;
  } sdfs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic stop_code;
  } sdfs_stat_t;

endpackage

// ===== rtl/sdfs_if.sv =====
// Valid/ready channel interfaces for digit words and pin-state words.
`timescale 1ns / 1ps
interface sdfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] digit_0;
  logic [3:0] digit_1;
  logic [3:0] digit_2;
  logic [3:0] digit_3;

  modport source (output valid, op, digit_0, digit_1, digit_2, digit_3, input ready);
  modport sink   (input valid, op, digit_0, digit_1, digit_2, digit_3, output ready);
endinterface

interface sdfs_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, clk_level, dio_level, busy_res, frame_done, input ready);
  modport sink   (input valid, clk_level, dio_level, busy_res, frame_done, output ready);
endinterface

// ===== rtl/sdfs_ctrl.sv =====
// Frame sequencer: phase, unit and bit counters, busy flag.
`timescale 1ns / 1ps
module sdfs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic                   op_i,
  input  sdfs_pkg::sdfs_stat_t   stat_i,
  output sdfs_pkg::sdfs_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   busy_d_o,
  output logic                   done_o
);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhStart0 = 4'd1;
  localparam logic [3:0] PhStart1 = 4'd2;
  localparam logic [3:0] PhStart2 = 4'd3;
  localparam logic [3:0] PhStart3 = 4'd4;
  localparam logic [3:0] PhBClkLo = 4'd5;
  localparam logic [3:0] PhBDio   = 4'd6;
  localparam logic [3:0] PhBClkHi = 4'd7;
  localparam logic [3:0] PhAckLo  = 4'd8;
  localparam logic [3:0] PhAckHi  = 4'd9;
  localparam logic [3:0] PhStop0  = 4'd10;
  localparam logic [3:0] PhStop1  = 4'd11;
  localparam logic [3:0] PhStop2  = 4'd12;
  localparam logic [3:0] PhStop3  = 4'd13;

  logic [3:0]                  phase_q, phase_d;
  logic [sdfs_pkg::UnitW-1:0]  unit_q, unit_d, unit_nx;
  logic [sdfs_pkg::BitW-1:0]   bit_q, bit_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic                        tick, advance, unit_cmd, nx_cmd;

  assign tick     = fire_i && !op_i && busy_q;
  assign unit_nx  = unit_q + sdfs_pkg::UnitW'(1);
  assign unit_cmd = (unit_q == sdfs_pkg::UnitDataSet) || (unit_q == sdfs_pkg::UnitAddress) ||
                    (unit_q == sdfs_pkg::UnitDisplay);
  assign nx_cmd   = (unit_nx == sdfs_pkg::UnitAddress) || (unit_nx == sdfs_pkg::UnitDisplay);

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    unit_d  = unit_q;
    bit_d   = bit_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    advance = 1'b0;
    cmd_o.bit_sel = bit_q;

    if (fire_i && op_i && !busy_q) begin
      cmd_o.load_digits = 1'b1;
      cmd_o.load_shift  = 1'b1;
      cmd_o.unit_sel    = sdfs_pkg::UnitDataSet;
      busy_d  = 1'b1;
      unit_d  = sdfs_pkg::UnitDataSet;
      bit_d   = '0;
      phase_d = PhStart0;
    end else if (tick) begin
      unique case (phase_q)
        PhStart0: begin cmd_o.clk_set = 1'b1; phase_d = PhStart1; end
        PhStart1: begin cmd_o.dio_set = 1'b1; phase_d = PhStart2; end
        PhStart2: begin cmd_o.dio_clr = 1'b1; phase_d = PhStart3; end
        PhStart3: begin cmd_o.clk_clr = 1'b1; phase_d = PhBClkLo; end
        PhBClkLo: begin cmd_o.clk_clr = 1'b1; phase_d = PhBDio;   end
        PhBDio:   begin cmd_o.dio_bit = 1'b1; phase_d = PhBClkHi; end
        PhBClkHi: begin
          cmd_o.clk_set = 1'b1;
          if (bit_q == '1) begin
            bit_d   = '0;
            phase_d = PhAckLo;
          end else begin
            bit_d   = bit_q + sdfs_pkg::BitW'(1);
            phase_d = PhBClkLo;
          end
        end
        PhAckLo:  begin cmd_o.clk_clr = 1'b1; phase_d = PhAckHi; end
        PhAckHi: begin
          cmd_o.clk_set = 1'b1;
          if (unit_cmd) begin
            if (stat_i.stop_code) phase_d = PhStop0;
            else                  advance = 1'b1;
          end else if (unit_q == sdfs_pkg::UnitLastDat) begin
            phase_d = PhStop0;
          end else begin
            advance = 1'b1;
          end
        end
        PhStop0:  begin cmd_o.clk_clr = 1'b1; phase_d = PhStop1; end
        PhStop1:  begin cmd_o.dio_clr = 1'b1; phase_d = PhStop2; end
        PhStop2:  begin cmd_o.clk_set = 1'b1; phase_d = PhStop3; end
        PhStop3:  begin cmd_o.dio_set = 1'b1; advance = 1'b1;    end
        default: begin
          // idle or undefined phase: drop the frame, pins hold
          busy_d  = 1'b0;
          phase_d = PhIdle;
          unit_d  = '0;
          bit_d   = '0;
        end
      endcase

      if (advance) begin
        if (unit_q >= sdfs_pkg::UnitDisplay) begin
          busy_d  = 1'b0;
          phase_d = PhIdle;
          unit_d  = '0;
          bit_d   = '0;
          done_d  = 1'b1;
        end else begin
          cmd_o.load_shift = 1'b1;
          cmd_o.unit_sel   = unit_nx;
          unit_d  = unit_nx;
          bit_d   = '0;
          phase_d = nx_cmd ? PhStart0 : PhBClkLo;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      unit_q  <= '0;
      bit_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      unit_q  <= unit_d;
      bit_q   <= bit_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o   = busy_q;
  assign busy_d_o = busy_d;
  assign done_o   = done_q;

endmodule

// ===== rtl/sdfs_dpath.sv =====
// Datapath: command registers, segment bytes, shift byte and pin registers.
`timescale 1ns / 1ps
module sdfs_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic                           cfg_we_i,
  input  logic [sdfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdfs_pkg::TableW-1:0]    cfg_wdata_i,
  input  logic [sdfs_pkg::Digits-1:0][3:0] digits_i,
  input  sdfs_pkg::sdfs_cmd_t            cmd_i,
  output sdfs_pkg::sdfs_stat_t           stat_o,
  output logic                           clk_pin_o,
  output logic                           dio_pin_o
);

  logic [7:0]                   cmd_data_set_q, cmd_address_q, cmd_display_q;
  logic [sdfs_pkg::TableW-1:0]  seg_low_q, seg_high_q;
  logic [sdfs_pkg::SegWidth-1:0] seg_q [sdfs_pkg::Digits];
  logic [sdfs_pkg::SegWidth-1:0] seg_d [sdfs_pkg::Digits];
  logic [7:0]                   shift_q, shift_d;
  logic [1:0]                   seg_sel;
  logic                         clk_q, dio_q;
  logic [sdfs_pkg::Digits:0]    shown;

  function automatic logic [sdfs_pkg::SegWidth-1:0] pattern_of(
    input logic [3:0] d, input logic [sdfs_pkg::TableW-1:0] lo,
    input logic [sdfs_pkg::TableW-1:0] hi);
    logic [sdfs_pkg::SegWidth-1:0] p;
    unique case (d)
      4'd1:    p = lo[13:7];
      4'd2:    p = lo[20:14];
      4'd3:    p = lo[27:21];
      4'd4:    p = lo[34:28];
      4'd5:    p = hi[6:0];
      4'd6:    p = hi[13:7];
      4'd7:    p = hi[20:14];
      4'd8:    p = hi[27:21];
      4'd9:    p = hi[34:28];
      default: p = lo[6:0];   // zero, and any value above nine
    endcase
    return p;
  endfunction

  // Leading-zero blanking; the last digit is always shown.
  always_comb begin
    shown[0] = 1'b0;
    for (int k = 0; k < sdfs_pkg::Digits; k++) begin
      shown[k+1] = shown[k] || (k == sdfs_pkg::Digits - 1) ||
                   ((digits_i[k] != 4'd0) && (digits_i[k] <= 4'd9));
      seg_d[k]   = shown[k+1] ? pattern_of(digits_i[k], seg_low_q, seg_high_q) : '0;
    end
  end

  assign seg_sel = 2'(cmd_i.unit_sel - sdfs_pkg::UnitW'(2));

  always_comb begin
    unique case (cmd_i.unit_sel)
      sdfs_pkg::UnitDataSet: shift_d = cmd_data_set_q;
      sdfs_pkg::UnitAddress: shift_d = cmd_address_q;
      sdfs_pkg::UnitDisplay: shift_d = cmd_display_q;
      default: begin
        // digits are latched on the same edge as the first command byte
        shift_d = {1'b0, seg_q[seg_sel]};
      end
    endcase
  end

  assign stat_o.stop_code = (shift_q == sdfs_pkg::StopCodeA) ||
                            (shift_q == sdfs_pkg::StopCodeB) ||
                            (shift_q == sdfs_pkg::StopCodeC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_data_set_q <= 8'h40;
      cmd_address_q  <= 8'hC0;
      cmd_display_q  <= 8'h88;
      seg_low_q      <= 35'd27547583295;
      seg_high_q     <= 35'd30062804717;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdfs_pkg::CfgDataSet: cmd_data_set_q <= cfg_wdata_i[7:0];
        sdfs_pkg::CfgAddress: cmd_address_q  <= cfg_wdata_i[7:0];
        sdfs_pkg::CfgDisplay: cmd_display_q  <= cfg_wdata_i[7:0];
        sdfs_pkg::CfgSegLow:  seg_low_q      <= cfg_wdata_i;
        sdfs_pkg::CfgSegHigh: seg_high_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sdfs_pkg::Digits; k++) seg_q[k] <= '0;
      shift_q <= '0;
      clk_q   <= 1'b0;
      dio_q   <= 1'b0;
    end else if (fire_i) begin
      if (cmd_i.load_digits) begin
        for (int k = 0; k < sdfs_pkg::Digits; k++) seg_q[k] <= seg_d[k];
      end
      if (cmd_i.load_shift) shift_q <= shift_d;
      if (cmd_i.clk_set) clk_q <= 1'b1;
      else if (cmd_i.clk_clr) clk_q <= 1'b0;
      if (cmd_i.dio_set) dio_q <= 1'b1;
      else if (cmd_i.dio_clr) dio_q <= 1'b0;
      else if (cmd_i.dio_bit) dio_q <= shift_q[cmd_i.bit_sel];
    end
  end

  assign clk_pin_o = clk_q;
  assign dio_pin_o = dio_q;

endmodule

// ===== rtl/segment_display_frame_sender.sv =====
// Top level of the two-wire seven-segment display frame sender.
`timescale 1ns / 1ps
// Usage:
//   in_i carries one word per tick: op=0 advances the link by one pin action,
//   op=1 loads digit_0..digit_3 (leading zeros blanked, last digit always
//   shown, values above nine shown as zero) and starts a frame. A load while
//   a frame is running is dropped and changes nothing.
//   out_o returns exactly one word per input word: clock and data pin levels
//   after that word, busy while a frame runs, frame_done on the tick that
//   performs the final pin action.
//   Output valid rises in the cycle after input accept. Throughput: one word
//   per cycle unless stalled; pin and status registers double as the output
//   register, so a new word is taken in the cycle its predecessor is read.
//   A full frame with default commands takes 7 command/data bytes of
//   26 to 34 ticks each; the tick rate sets the bit timing on the wires.
//   Stall: while out_o is valid and not ready, in_i.ready is low and all
//   state holds.
//   Reset: pins low, idle, command bytes 0x40/0xC0/0x88, default digit
//   patterns. cfg_we_i writes register cfg_idx_i; unknown indexes are ignored.
`include "assert_macros.svh"

module segment_display_frame_sender (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sdfs_in_if.sink                      in_i,
  sdfs_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [sdfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sdfs_pkg::TableW-1:0]  cfg_wdata_i
);

  sdfs_pkg::sdfs_cmd_t  cmd;
  sdfs_pkg::sdfs_stat_t stat;
  logic                 fire;
  logic                 out_valid_q;
  logic                 busy, busy_next, done;
  logic                 clk_pin, dio_pin;
  logic [sdfs_pkg::Digits-1:0][3:0] digits;

  // Output slot frees in the same cycle it is read.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign digits = {in_i.digit_3, in_i.digit_2, in_i.digit_1, in_i.digit_0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  sdfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .op_i     (in_i.op),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .busy_d_o (busy_next),
    .done_o   (done)
  );

  sdfs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .digits_i    (digits),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .clk_pin_o   (clk_pin),
    .dio_pin_o   (dio_pin)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.clk_level  = clk_pin;
  assign out_o.dio_level  = dio_pin;
  assign out_o.busy_res   = busy;
  assign out_o.frame_done = done;

  // A finished frame is never reported as still busy.
  `SDFS_ASSERT_IMP(a_done_not_busy, out_o.valid && out_o.frame_done, !out_o.busy_res,
                   "frame_done with busy set")
  // A load taken while idle starts a frame on the next output word.
  `SDFS_ASSERT(a_load_starts, (fire && in_i.op && !busy) |=> (out_o.valid && out_o.busy_res),
               "load did not start a frame")
  // An empty output slot never blocks the input.
  `SDFS_ASSERT_IMP(a_ready_when_empty, !out_o.valid, in_i.ready, "input stalled with empty output")
  // Busy flag seen at the output matches what the sequencer decided.
  `SDFS_ASSERT(a_busy_track, fire |=> (busy == $past(busy_next)), "busy flag mismatch")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the two-wire segment display frame sender.
`timescale 1ns / 1ps
module tb;

  // Pin sequencer phases of the predictor.
  typedef enum logic [4:0] {
    PhIdle, PhStart0, PhStart1, PhStart2, PhStart3,
    PhBitClkLo, PhBitDio, PhBitClkHi, PhAckLo, PhAckHi,
    PhStop0, PhStop1, PhStop2, PhStop3
  } link_phase_e;

  // One result word: pin levels and status after one input word.
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy;
    logic done;
  } pin_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [sdfs_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [sdfs_pkg::TableW-1:0] cfg_wdata_i;

  sdfs_in_if in_if ();
  sdfs_out_if out_if ();

  segment_display_frame_sender dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor copy of the configuration.
  logic [7:0]                  reg_data_set;
  logic [7:0]                  reg_address;
  logic [7:0]                  reg_display;
  logic [sdfs_pkg::TableW-1:0] reg_seg_lo;
  logic [sdfs_pkg::TableW-1:0] reg_seg_hi;

  // Predictor copy of the link state.
  logic [7:0]                 seg_bytes [sdfs_pkg::Digits];
  logic [sdfs_pkg::UnitW-1:0] unit_q;
  logic [sdfs_pkg::BitW-1:0]  bit_pos;
  link_phase_e                link_phase;
  logic [7:0]                 shift_q;
  logic                       clk_q;
  logic                       dio_q;
  logic                       busy_q;

  pin_word_t exp_pins_q [$];
  int        pin_errors = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Digits above nine show as zero.
  function automatic logic [6:0] seg_of(logic [3:0] d);
    logic [3:0] v;
    v = (d > 4'd9) ? 4'd0 : d;
    if (v < 4'd5) return reg_seg_lo[7*v +: 7];
    return reg_seg_hi[7*(v-4'd5) +: 7];
  endfunction

  // Command units get start framing, data units do not.
  function automatic logic is_cmd_unit(logic [sdfs_pkg::UnitW-1:0] u);
    return (u < 2) || (u == sdfs_pkg::UnitDisplay);
  endfunction

  function automatic logic is_stop_code(logic [7:0] b);
    return (b == sdfs_pkg::StopCodeA) || (b == sdfs_pkg::StopCodeB) ||
           (b == sdfs_pkg::StopCodeC);
  endfunction

  function automatic void load_unit();
    if (unit_q == sdfs_pkg::UnitDataSet) shift_q = reg_data_set;
    else if (unit_q == sdfs_pkg::UnitAddress) shift_q = reg_address;
    else if (unit_q == sdfs_pkg::UnitDisplay) shift_q = reg_display;
    else shift_q = seg_bytes[2'(unit_q - sdfs_pkg::UnitW'(2))];
    bit_pos = '0;
    link_phase = is_cmd_unit(unit_q) ? PhStart0 : PhBitClkLo;
  endfunction

  // Step to the next unit; returns 1 when the display byte was the last one.
  function automatic logic next_unit();
    if (unit_q >= sdfs_pkg::UnitDisplay) begin
      busy_q = 1'b0;
      link_phase = PhIdle;
      unit_q = '0;
      bit_pos = '0;
      return 1'b1;
    end
    unit_q = unit_q + 1'b1;
    load_unit();
    return 1'b0;
  endfunction

  function automatic pin_word_t advance_link(logic op, logic [3:0][3:0] dig);
    logic       done;
    logic       shown;
    logic [3:0] v;
    done = 1'b0;
    if (op) begin
      // a load while busy is dropped
      if (!busy_q) begin
        shown = 1'b0;
        for (int k = 0; k < sdfs_pkg::Digits; k++) begin
          v = (dig[k] > 4'd9) ? 4'd0 : dig[k];
          if (v != 4'd0 || k == sdfs_pkg::Digits - 1) shown = 1'b1;
          seg_bytes[k] = shown ? {1'b0, seg_of(v)} : 8'h00;
        end
        busy_q = 1'b1;
        unit_q = '0;
        load_unit();
      end
    end else if (busy_q) begin
      case (link_phase)
        PhStart0: begin clk_q = 1'b1; link_phase = PhStart1; end
        PhStart1: begin dio_q = 1'b1; link_phase = PhStart2; end
        PhStart2: begin dio_q = 1'b0; link_phase = PhStart3; end
        PhStart3: begin clk_q = 1'b0; link_phase = PhBitClkLo; end
        PhBitClkLo: begin clk_q = 1'b0; link_phase = PhBitDio; end
        PhBitDio: begin dio_q = shift_q[bit_pos]; link_phase = PhBitClkHi; end
        PhBitClkHi: begin
          clk_q = 1'b1;
          if (bit_pos == 3'd7) begin
            bit_pos = '0;
            link_phase = PhAckLo;
          end else begin
            bit_pos = bit_pos + 1'b1;
            link_phase = PhBitClkLo;
          end
        end
        PhAckLo: begin clk_q = 1'b0; link_phase = PhAckHi; end
        PhAckHi: begin
          clk_q = 1'b1;
          if (is_cmd_unit(unit_q)) begin
            if (is_stop_code(shift_q)) link_phase = PhStop0;
            else done = next_unit();
          end else if (unit_q == sdfs_pkg::UnitLastDat) begin
            link_phase = PhStop0;
          end else begin
            done = next_unit();
          end
        end
        PhStop0: begin clk_q = 1'b0; link_phase = PhStop1; end
        PhStop1: begin dio_q = 1'b0; link_phase = PhStop2; end
        PhStop2: begin clk_q = 1'b1; link_phase = PhStop3; end
        PhStop3: begin dio_q = 1'b1; done = next_unit(); end
        default: begin
          busy_q = 1'b0;
          link_phase = PhIdle;
          unit_q = '0;
          bit_pos = '0;
        end
      endcase
    end
    return '{clk_level: clk_q, dio_level: dio_q, busy: busy_q, done: done};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Sends one word; starts and ends at a falling edge with valid still high,
  // so the caller must present the next word or lower valid right away.
  task automatic send_word(logic op, logic [3:0][3:0] dig);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.digit_0 <= dig[0];
    in_if.digit_1 <= dig[1];
    in_if.digit_2 <= dig[2];
    in_if.digit_3 <= dig[3];
    do @(posedge clk_i); while (!in_if.ready);
    exp_pins_q.push_back(advance_link(op, dig));
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_word(1'b0, {4{4'($urandom_range(15))}});
  endtask

  // Ticks until the predicted frame has ended.
  task automatic finish_frame();
    while (busy_q) send_tick();
  endtask

  // Holds the sender off until every expected word has come back.
  task automatic wait_words_drained();
    in_if.valid <= 1'b0;
    while (exp_pins_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write; write enable stays high for a following write.
  task automatic put_reg(sdfs_pkg::cfg_idx_e idx, logic [sdfs_pkg::TableW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      sdfs_pkg::CfgDataSet: reg_data_set = val[7:0];
      sdfs_pkg::CfgAddress: reg_address  = val[7:0];
      sdfs_pkg::CfgDisplay: reg_display  = val[7:0];
      sdfs_pkg::CfgSegLow:  reg_seg_lo   = val;
      sdfs_pkg::CfgSegHigh: reg_seg_hi   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Writes all five registers; only called with the link idle and drained.
  task automatic apply_settings(logic [7:0] ds, logic [7:0] ad, logic [7:0] dp,
                                logic [sdfs_pkg::TableW-1:0] lo,
                                logic [sdfs_pkg::TableW-1:0] hi);
    wait_words_drained();
    put_reg(sdfs_pkg::CfgDataSet, sdfs_pkg::TableW'(ds));
    put_reg(sdfs_pkg::CfgAddress, sdfs_pkg::TableW'(ad));
    put_reg(sdfs_pkg::CfgDisplay, sdfs_pkg::TableW'(dp));
    put_reg(sdfs_pkg::CfgSegLow, lo);
    put_reg(sdfs_pkg::CfgSegHigh, hi);
    cfg_we_i <= 1'b0;
  endtask

  // Commands are stop codes often enough to exercise both framings.
  function automatic logic [7:0] rand_cmd();
    case ($urandom_range(5))
      0: return sdfs_pkg::StopCodeA;
      1: return sdfs_pkg::StopCodeB;
      2: return sdfs_pkg::StopCodeC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [sdfs_pkg::TableW-1:0] rand_table();
    return sdfs_pkg::TableW'({$urandom, $urandom});
  endfunction

  // Zero is drawn often so that leading-zero blanking comes up a lot.
  function automatic logic [3:0] rand_digit();
    return ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: every accepted output word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : pin_checker
    pin_word_t got;
    pin_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{clk_level: out_if.clk_level, dio_level: out_if.dio_level,
              busy: out_if.busy_res, done: out_if.frame_done};
      if (exp_pins_q.size() == 0) begin
        pin_errors++;
        if (pin_errors <= 10)
          $display("%0t: word with nothing expected: clk %b dio %b busy %b done %b",
                   $realtime, got.clk_level, got.dio_level, got.busy, got.done);
      end else begin
        want = exp_pins_q.pop_front();
        if (got.clk_level !== want.clk_level || got.dio_level !== want.dio_level ||
            got.busy !== want.busy || got.done !== want.done) begin
          pin_errors++;
          if (pin_errors <= 10)
            $display("%0t: mismatch exp clk %b dio %b busy %b done %b, got %b %b %b %b",
                     $realtime, want.clk_level, want.dio_level, want.busy, want.done,
                     got.clk_level, got.dio_level, got.busy, got.done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks while idle do nothing; a load mid-frame is dropped.
  task automatic test_idle_and_busy_load();
    send_tick();
    send_tick();
    send_word(1'b1, {4'd0, 4'd0, 4'd0, 4'd0});
    repeat (40) send_tick();
    send_word(1'b1, {4'd4, 4'd3, 4'd2, 4'd1});
    repeat (100) send_tick();
    send_word(1'b1, {4'd8, 4'd8, 4'd8, 4'd8});
    finish_frame();
    send_tick();
  endtask

  // Leading-zero blanking and out-of-range digits, blanked and shown.
  // Packed order is {digit_3, digit_2, digit_1, digit_0}.
  task automatic test_digit_patterns();
    logic [3:0][3:0] pats [3];
    pats = '{{4'd7, 4'd0, 4'd0, 4'd0},
             {4'd1, 4'd12, 4'd0, 4'd10},
             {4'd15, 4'd9, 4'd9, 4'd15}};
    foreach (pats[i]) begin
      send_word(1'b1, pats[i]);
      finish_frame();
    end
  endtask

  // Register extremes and command values on and off the stop list.
  task automatic test_config_extremes();
    apply_settings(8'h00, 8'hFF, 8'hFF, '1, '0);
    send_word(1'b1, {4'd6, 4'd3, 4'd8, 4'd1});
    finish_frame();
    apply_settings(sdfs_pkg::StopCodeB, sdfs_pkg::StopCodeA, sdfs_pkg::StopCodeB,
                   rand_table(), rand_table());
    send_word(1'b1, {4'd5, 4'd0, 4'd6, 4'd0});
    finish_frame();
  endtask

  // Mostly whole frames with random digits, plus dropped loads and idle ticks.
  task automatic test_random_frames(int n_words, int s_idle, int k_idle);
    int              counted;
    logic            paused;
    logic [3:0][3:0] dig;
    apply_settings(rand_cmd(), rand_cmd(), rand_cmd(), rand_table(), rand_table());
    src_idle_pct = s_idle;
    snk_idle_pct = k_idle;
    counted = 0;
    paused = 1'b0;
    while (counted < n_words || busy_q) begin
      // sender holds off once until everything has come back
      if (!paused && counted >= n_words / 2) begin
        paused = 1'b1;
        wait_words_drained();
      end
      for (int k = 0; k < sdfs_pkg::Digits; k++) dig[k] = rand_digit();
      if (busy_q) begin
        if ($urandom_range(99) < 2) begin
          send_word(1'b1, dig);
        end else begin
          send_word(1'b0, dig);
          counted++;
        end
      end else if ($urandom_range(99) < 85) begin
        send_word(1'b1, dig);
        counted++;
      end else begin
        send_word(1'b0, dig);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // model and ports at reset values from time zero
    reg_data_set = 8'h40;
    reg_address  = 8'hC0;
    reg_display  = 8'h88;
    reg_seg_lo   = 35'd27547583295;
    reg_seg_hi   = 35'd30062804717;
    foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
    unit_q     = '0;
    bit_pos    = '0;
    link_phase = PhIdle;
    shift_q    = 8'h00;
    clk_q      = 1'b0;
    dio_q      = 1'b0;
    busy_q     = 1'b0;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sdfs_pkg::CfgDataSet;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.op      = 1'b0;
    in_if.digit_0 = 4'd0;
    in_if.digit_1 = 4'd0;
    in_if.digit_2 = 4'd0;
    in_if.digit_3 = 4'd0;
    out_if.ready  = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part under the first idling mix, reset settings first
    src_idle_pct = 38;
    snk_idle_pct = 85;
    test_idle_and_busy_load();
    test_digit_patterns();
    test_config_extremes();

    test_random_frames(200, 85, 38);
    test_random_frames(200, 0, 0);

    wait_words_drained();
    repeat (8) @(posedge clk_i);
    if (pin_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
